[sv/tods_pkg.sv]
// shared types, constants and codes of the time-of-day task scheduler
package tods_pkg;

  localparam int ENTRIES     = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 17;
  localparam int MASK_W      = 51;

  // commands
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // result kinds and status codes
  localparam logic       KIND_ADD   = 1'b0;
  localparam logic       KIND_TASK  = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADTYPE = 2'd2;

  // trigger types
  localparam logic [2:0] TRIG_ONCE  = 3'd0;
  localparam logic [2:0] TRIG_MDAY  = 3'd1;
  localparam logic [2:0] TRIG_WEEK  = 3'd2;
  localparam logic [2:0] TRIG_MONTH = 3'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_HOUR   = 2'd0;
  localparam logic [1:0] CFG_MINUTE = 2'd1;
  localparam logic [1:0] CFG_SECOND = 2'd2;
  localparam logic [1:0] CFG_MDAY   = 2'd3;

  // time of day at a day change
  localparam logic [TIME_W-1:0] END_OF_DAY = {5'd23, 6'd59, 6'd59};

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  task_id;
    logic [2:0]  trig_type;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] mday_mask;
    logic [6:0]  wday_mask;
    logic [11:0] month_mask;
    logic [4:0]  day_of_month;
    logic [2:0]  day_of_week;
    logic [3:0]  month;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] slot;
    logic       fired;
    logic [1:0] status;
    logic       last;
  } out_t;

  // one slot record in the task memory
  typedef struct packed {
    logic [2:0]        trig_type;
    logic [TIME_W-1:0] trig_time;
    logic [MASK_W-1:0] masks;
  } slot_rec_t;

  // current wall date used for matching
  typedef struct packed {
    logic [4:0] mday;
    logic [2:0] wday;
    logic [3:0] mon;
  } date_t;

endpackage

[sv/tods_ram.sv]
// generic single-write, single-read ram with registered read data
module tods_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/tods_match.sv]
// trigger mask match: decides whether a due task fires
module tods_match import tods_pkg::*; (
  input  slot_rec_t  rec_i,
  input  date_t      date_i,
  output logic       fired_o,
  output logic [1:0] status_o
);

  logic mday_ok, wday_ok, mon_ok;

  // per-mask bit tests, out-of-range weekday or month never matches
  always_comb begin
    mday_ok = rec_i.masks[date_i.mday];
    wday_ok = (date_i.wday < 3'd7) && rec_i.masks[6'd32 + {3'd0, date_i.wday}];
    mon_ok  = (date_i.mon < 4'd12) && rec_i.masks[6'd39 + {2'd0, date_i.mon}];
  end

  // type decode
  always_comb begin
    fired_o  = 1'b0;
    status_o = ST_OK;
    unique case (rec_i.trig_type)
      TRIG_ONCE:  fired_o = 1'b1;
      TRIG_MDAY:  fired_o = mday_ok;
      TRIG_WEEK:  fired_o = wday_ok;
      TRIG_MONTH: fired_o = mon_ok && mday_ok;
      default:    status_o = ST_BADTYPE;
    endcase
  end

endmodule

[sv/time_of_day_task_scheduler.sv]
// top level of the time-of-day task scheduler
// Add and remove are accepted when the scheduler is idle and the output
// register is free. A tick scans the whole task memory through the single
// read port of the slot memory and then decides; after each due task that
// it emits it scans again, until no due task is left or MAX_RESULTS results
// are out. Results leave through a one-deep output register; each result is
// held back until the next scan shows whether it is the last of its tick.
module time_of_day_task_scheduler import tods_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [5:0] cfg_wdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;

  logic [2:0]         state_q, state_d;
  logic [ENTRIES-1:0] valid_q, valid_d, en_q, en_d, inset_q, inset_d;
  logic               sel_q, sel_d, started_q, started_d;
  logic [21:0]        kept_q, kept_d, kept_eff;
  logic [4:0]         sh_q, sd_q;
  logic [5:0]         sm_q, ss_q;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               best_found_q, best_found_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  slot_rec_t          best_q, best_d;
  logic [TIME_W-1:0]  now_q, now_d;
  date_t              date_q, date_d;
  logic               newday_q, newday_d;
  logic [NRES_W-1:0]  nres_q, nres_d;
  logic               held_vld_q, held_vld_d;
  out_t               held_q, held_d;
  logic               out_vld_q, out_vld_d;
  out_t               out_q, out_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  slot_rec_t          ram_wdata, ram_rdata;

  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               in_acc;
  logic [TIME_W-1:0]  add_time;
  logic               m_fired;
  logic [1:0]         m_status;
  logic               take;

  // slot record memory
  tods_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // fire decision for the selected task
  tods_match u_match (
    .rec_i    (best_q),
    .date_i   (date_q),
    .fired_o  (m_fired),
    .status_o (m_status)
  );

  // start registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q <= '0;
      sm_q <= '0;
      ss_q <= '0;
      sd_q <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HOUR:   sh_q <= cfg_wdata_i[4:0];
        CFG_MINUTE: sm_q <= cfg_wdata_i;
        CFG_SECOND: ss_q <= cfg_wdata_i;
        CFG_MDAY:   sd_q <= cfg_wdata_i[4:0];
        default:    ;
      endcase
    end
  end

  assign kept_eff = started_q ? kept_q : {sd_q, sh_q, sm_q, ss_q};

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE) || out_vld_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign add_time   = {in_data_i.hour, in_data_i.minute, in_data_i.second};
  assign take       = best_found_q && (best_q.trig_time <= now_q) &&
                      (nres_q < NRES_W'(MAX_RESULTS));

  // memory write port carries adds only
  assign ram_we    = in_acc && (in_data_i.cmd == CMD_ADD) && free_found;
  assign ram_waddr = free_idx;
  assign ram_wdata = '{trig_type: in_data_i.trig_type, trig_time: add_time,
                       masks: {in_data_i.month_mask, in_data_i.wday_mask,
                               in_data_i.mday_mask}};
  assign ram_raddr = cnt_q[IDX_W-1:0];

  // command handling, scan and result sequencing
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    en_d         = en_q;
    inset_d      = inset_q;
    sel_d        = sel_q;
    started_d    = started_q;
    kept_d       = kept_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    now_d        = now_q;
    date_d       = date_q;
    newday_d     = newday_q;
    nres_d       = nres_q;
    held_vld_d   = held_vld_q;
    held_d       = held_q;
    out_vld_d    = out_vld_q && out_stall_i;
    out_d        = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.cmd)
            CMD_ADD: begin
              out_vld_d = 1'b1;
              out_d     = '{kind: KIND_ADD, slot: '0, fired: 1'b0,
                            status: ST_FULL, last: 1'b1};
              if (free_found) begin
                valid_d[free_idx] = 1'b1;
                en_d[free_idx]    = 1'b1;
                inset_d[free_idx] = (add_time <= kept_eff[16:0]) ? !sel_q : sel_q;
                out_d.slot        = 5'(free_idx);
                out_d.status      = ST_OK;
              end
            end
            CMD_REMOVE: begin
              if ((32'(in_data_i.task_id) < ENTRIES) &&
                  valid_q[IDX_W'(in_data_i.task_id)]) begin
                en_d[IDX_W'(in_data_i.task_id)] = 1'b0;
              end
            end
            CMD_TICK: begin
              newday_d     = kept_eff[21:17] != in_data_i.day_of_month;
              now_d        = newday_d ? END_OF_DAY : add_time;
              kept_d       = {in_data_i.day_of_month, now_d};
              started_d    = 1'b1;
              date_d       = '{mday: in_data_i.day_of_month,
                               wday: in_data_i.day_of_week, mon: in_data_i.month};
              nres_d       = '0;
              cnt_d        = '0;
              best_found_d = 1'b0;
              held_vld_d   = 1'b0;
              state_d      = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // compare the beat read in the previous cycle
        if (rd_vld_q && valid_q[rd_idx_q] && (inset_q[rd_idx_q] == sel_q) &&
            (!best_found_q || (ram_rdata.trig_time < best_q.trig_time))) begin
          best_found_d = 1'b1;
          best_idx_d   = rd_idx_q;
          best_d       = ram_rdata;
        end
        if (cnt_q != CNT_W'(ENTRIES)) begin
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[IDX_W-1:0];
          cnt_d    = cnt_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!(held_vld_q && out_vld_q)) begin
          if (held_vld_q) begin
            out_vld_d  = 1'b1;
            out_d      = held_q;
            out_d.last = !take;
          end
          if (take) begin
            held_vld_d = 1'b1;
            held_d     = '{kind: KIND_TASK, slot: 5'(best_idx_q), fired: m_fired,
                           status: m_status, last: 1'b0};
            if (en_q[best_idx_q]) begin
              inset_d[best_idx_q] = !sel_q;
            end else begin
              valid_d[best_idx_q] = 1'b0;
              en_d[best_idx_q]    = 1'b0;
            end
            nres_d       = nres_q + 1'b1;
            cnt_d        = '0;
            best_found_d = 1'b0;
            state_d      = S_SCAN;
          end else begin
            held_vld_d = 1'b0;
            if (newday_q) begin
              sel_d = !sel_q;
            end
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      en_q       <= '0;
      sel_q      <= 1'b0;
      started_q  <= 1'b0;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      best_found_q <= 1'b0;
      nres_q     <= '0;
      held_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      en_q       <= en_d;
      sel_q      <= sel_d;
      started_q  <= started_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      best_found_q <= best_found_d;
      nres_q     <= nres_d;
      held_vld_q <= held_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    inset_q    <= inset_d;
    kept_q     <= kept_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    now_q      <= now_d;
    date_q     <= date_d;
    newday_q   <= newday_d;
    held_q     <= held_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !held_vld_q)
    else $error("held result left over in idle");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (state_q == S_IDLE) && !out_vld_q)
    else $error("input accepted while busy");
  a_nres_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= NRES_W'(MAX_RESULTS))
    else $error("too many results for one tick");
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) && held_vld_q && !out_vld_q |=> out_vld_q)
    else $error("held result not pushed");
`endif

endmodule
